FILE: hw/rtl/rplzd_pkg.sv
// ----------------------------------------------------------------------------
// rplzd_pkg
// Shared types and constants for the RefPack LZ decompressor: channel
// payloads, status codes, tag class boundaries and default sizes.
// ----------------------------------------------------------------------------
package rplzd_pkg;

  // Default sizes
  localparam int WINDOW_BYTES_DFLT = 131072;
  localparam int COUNT_BITS_DFLT   = 24;

  // Fixed field widths
  localparam int SIZE_W = 24;  // expected_size register
  localparam int DIST_W = 18;  // match distance, up to 131072
  localparam int COPY_W = 11;  // match length, up to 1028
  localparam int LIT_W  = 8;   // literal run, up to 112

  // Output queue
  localparam int             OQ_DEPTH = 4;
  localparam int             OQ_AW    = 2;
  localparam int             OQ_CW    = 3;
  localparam logic [OQ_CW-1:0] OQ_HIWAT = 3'd3;

  // Tag class boundaries
  localparam logic [7:0] TAG_MED  = 8'h80;
  localparam logic [7:0] TAG_LONG = 8'hC0;
  localparam logic [7:0] TAG_RUN  = 8'hE0;
  localparam logic [7:0] TAG_STOP = 8'hFC;

  typedef logic [2:0] status_t;

  // Status codes
  localparam status_t ST_RUN      = 3'd0;
  localparam status_t ST_OK       = 3'd1;
  localparam status_t ST_TRUNC    = 3'd2;
  localparam status_t ST_DIST     = 3'd3;
  localparam status_t ST_SIZE     = 3'd4;
  localparam status_t ST_COPYBYTE = 3'd5;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
    logic       is_last;
  } rplzd_in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    status_t    status;
  } rplzd_out_t;

  // Decode result of one item, handed from the parser to the byte stage
  typedef struct packed {
    logic       emit;
    logic       from_hist;
    logic [7:0] lit_byte;
    logic       copy_pending;
    status_t    status;
  } rplzd_req_t;

endpackage

FILE: hw/rtl/rplzd_ram.sv
// ----------------------------------------------------------------------------
// rplzd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (old data on a same-address write).
// ----------------------------------------------------------------------------
module rplzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/rplzd_ctrl.sv
// ----------------------------------------------------------------------------
// rplzd_ctrl
// Tag parser and stream bookkeeping. Decodes one item per transfer, keeps
// counters, distance, output count and history write pointer, and issues the
// history read address for copy steps.
// ----------------------------------------------------------------------------
module rplzd_ctrl
  import rplzd_pkg::*;
#(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DFLT,
  parameter int COUNT_BITS   = COUNT_BITS_DFLT,
  localparam int AW = $clog2(WINDOW_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              in_fire,
  input  rplzd_in_t         in_data,
  output rplzd_req_t        req,
  output logic [AW-1:0]     rd_addr,
  output logic [AW-1:0]     wr_addr
);

  localparam int CMP_W = (COUNT_BITS > SIZE_W) ? COUNT_BITS : SIZE_W;
  localparam int PW    = DIST_W + 1;
  localparam logic [PW-1:0]     WIN_P = PW'(WINDOW_BYTES);
  localparam logic [DIST_W-1:0] WIN_D = DIST_W'(WINDOW_BYTES);
  localparam logic [AW:0]       WIN_A = (AW+1)'(WINDOW_BYTES);

  // Parse phases
  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_EXT  = 2'd1;
  localparam logic [1:0] PH_LIT  = 2'd2;
  localparam logic [1:0] PH_COPY = 2'd3;

  logic [SIZE_W-1:0]     expected_r;
  logic [1:0]            phase_r,  phase_nxt;
  logic [15:0]           tag_r,    tag_nxt;
  logic [7:0]            lead_r,   lead_nxt;
  logic [1:0]            extra_r,  extra_nxt;
  logic [LIT_W-1:0]      lit_r,    lit_nxt;
  logic [COPY_W-1:0]     copy_r,   copy_nxt;
  logic [DIST_W-1:0]     dist_r,   dist_nxt;
  logic [COUNT_BITS-1:0] prod_r,   prod_nxt;
  logic [AW-1:0]         wptr_r,   wptr_nxt;
  status_t               fin_r,    fin_nxt;
  logic                  stop_r,   stop_nxt;
  logic                  idone_r,  idone_nxt;

  logic [CMP_W-1:0] exp_x;
  logic [PW-1:0]    wptr_p;
  logic [PW-1:0]    dist_p;
  logic [PW-1:0]    pos_raw;
  logic [AW:0]      wptr_inc;
  logic [AW-1:0]    wptr_adv;
  logic [7:0]       b_in;

  function automatic status_t f_finish(input status_t fin, input status_t code);
    return (fin == ST_RUN) ? code : fin;
  endfunction

  function automatic status_t f_size_end(input status_t fin,
                                         input logic [CMP_W-1:0] prod,
                                         input logic [CMP_W-1:0] exp_sz);
    return f_finish(fin, (prod == exp_sz) ? ST_OK : ST_SIZE);
  endfunction

  function automatic status_t f_boundary(input status_t fin,
                                         input logic [CMP_W-1:0] prod,
                                         input logic [CMP_W-1:0] exp_sz,
                                         input logic done);
    status_t res;
    res = fin;
    if (prod >= exp_sz) begin
      res = f_size_end(fin, prod, exp_sz);
    end else if (done) begin
      res = f_finish(fin, ST_SIZE);
    end
    return res;
  endfunction

  assign exp_x = CMP_W'(expected_r);
  assign b_in  = in_data.byte_in;

  // History read position, wrapped into the window
  assign wptr_p  = PW'(wptr_r);
  assign dist_p  = PW'(dist_r);
  assign pos_raw = (wptr_p >= dist_p) ? wptr_p - dist_p : wptr_p + WIN_P - dist_p;
  assign rd_addr = (pos_raw >= WIN_P) ? '0 : pos_raw[AW-1:0];
  assign wr_addr = wptr_r;

  // Advance the write pointer with wrap
  assign wptr_inc = {1'b0, wptr_r} + (AW+1)'(1);
  assign wptr_adv = (wptr_inc >= WIN_A) ? '0 : wptr_inc[AW-1:0];

  // Decode one item
  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    lead_nxt  = lead_r;
    extra_nxt = extra_r;
    lit_nxt   = lit_r;
    copy_nxt  = copy_r;
    dist_nxt  = dist_r;
    prod_nxt  = prod_r;
    wptr_nxt  = wptr_r;
    fin_nxt   = fin_r;
    stop_nxt  = stop_r;
    idone_nxt = idone_r;
    req       = '0;

    // Check the size at an idle command boundary
    if (fin_nxt == ST_RUN && phase_nxt == PH_TAG) begin
      fin_nxt = f_boundary(fin_nxt, CMP_W'(prod_nxt), exp_x, idone_nxt);
    end

    if (fin_nxt == ST_RUN) begin
      if (in_data.kind) begin
        // Step: copy one byte from history
        if (phase_nxt == PH_COPY) begin
          req.emit      = 1'b1;
          req.from_hist = 1'b1;
          wptr_nxt      = wptr_adv;
          if (&prod_nxt) begin
            fin_nxt = f_finish(fin_nxt, ST_SIZE);
          end else begin
            prod_nxt = prod_nxt + COUNT_BITS'(1);
          end
          copy_nxt = copy_nxt - COPY_W'(1);
          if (fin_nxt == ST_RUN && copy_nxt == '0) begin
            phase_nxt = PH_TAG;
            fin_nxt   = f_boundary(fin_nxt, CMP_W'(prod_nxt), exp_x, idone_nxt);
          end
        end
      end else if (phase_nxt == PH_COPY) begin
        // Drop a byte that arrives during a copy and end with ST_COPYBYTE
        fin_nxt = f_finish(fin_nxt, ST_COPYBYTE);
      end else begin
        if (in_data.is_last) begin
          idone_nxt = 1'b1;
        end
        case (phase_nxt)
          PH_TAG: begin
            lead_nxt = b_in;
            tag_nxt  = '0;
            if (b_in < TAG_RUN) begin
              extra_nxt = (b_in < TAG_MED) ? 2'd1 : (b_in < TAG_LONG) ? 2'd2 : 2'd3;
              phase_nxt = PH_EXT;
            end else if (b_in < TAG_STOP) begin
              lit_nxt   = LIT_W'({b_in[4:0], 2'b00}) + LIT_W'(4);
              copy_nxt  = '0;
              stop_nxt  = 1'b0;
              phase_nxt = PH_LIT;
            end else begin
              lit_nxt   = LIT_W'(b_in[1:0]);
              copy_nxt  = '0;
              stop_nxt  = 1'b1;
              phase_nxt = PH_LIT;
              if (lit_nxt == '0) begin
                fin_nxt = f_size_end(fin_nxt, CMP_W'(prod_nxt), exp_x);
              end
            end
          end
          PH_EXT: begin
            extra_nxt = extra_nxt - 2'd1;
            if (extra_nxt == 2'd0) begin
              // Unpack the match fields of the tag
              if (lead_r < TAG_MED) begin
                lit_nxt  = LIT_W'(lead_r[1:0]);
                copy_nxt = COPY_W'(lead_r[4:2]) + COPY_W'(3);
                dist_nxt = DIST_W'({lead_r[6:5], b_in}) + DIST_W'(1);
              end else if (lead_r < TAG_LONG) begin
                lit_nxt  = LIT_W'(tag_r[7:6]);
                copy_nxt = COPY_W'(lead_r[5:0]) + COPY_W'(4);
                dist_nxt = DIST_W'({tag_r[5:0], b_in}) + DIST_W'(1);
              end else begin
                lit_nxt  = LIT_W'(lead_r[1:0]);
                copy_nxt = COPY_W'({lead_r[3:2], b_in}) + COPY_W'(5);
                dist_nxt = DIST_W'({lead_r[4], tag_r}) + DIST_W'(1);
              end
              stop_nxt = 1'b0;
              if (lit_nxt != '0) begin
                phase_nxt = PH_LIT;
              end else if (CMP_W'(dist_nxt) > CMP_W'(prod_nxt) || dist_nxt > WIN_D) begin
                fin_nxt = f_finish(fin_nxt, ST_DIST);
              end else begin
                phase_nxt = PH_COPY;
              end
            end else begin
              tag_nxt = {tag_nxt[7:0], b_in};
            end
          end
          default: begin
            // Literal byte goes straight out
            req.emit     = 1'b1;
            req.lit_byte = b_in;
            wptr_nxt     = wptr_adv;
            if (&prod_nxt) begin
              fin_nxt = f_finish(fin_nxt, ST_SIZE);
            end else begin
              prod_nxt = prod_nxt + COUNT_BITS'(1);
            end
            lit_nxt = lit_nxt - LIT_W'(1);
            if (fin_nxt == ST_RUN && lit_nxt == '0) begin
              if (stop_nxt) begin
                fin_nxt = f_size_end(fin_nxt, CMP_W'(prod_nxt), exp_x);
              end else if (copy_nxt != '0) begin
                if (CMP_W'(dist_nxt) > CMP_W'(prod_nxt) || dist_nxt > WIN_D) begin
                  fin_nxt = f_finish(fin_nxt, ST_DIST);
                end else begin
                  phase_nxt = PH_COPY;
                end
              end else begin
                phase_nxt = PH_TAG;
                fin_nxt   = f_boundary(fin_nxt, CMP_W'(prod_nxt), exp_x, idone_nxt);
              end
            end
          end
        endcase
        // Input ended inside a tag or literal run
        if (fin_nxt == ST_RUN && idone_nxt && (phase_nxt inside {PH_EXT, PH_LIT})) begin
          fin_nxt = ST_TRUNC;
        end
      end
    end

    req.copy_pending = (fin_nxt == ST_RUN) && (phase_nxt == PH_COPY);
    req.status       = fin_nxt;
  end

  // Commit state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      phase_r    <= PH_TAG;
      tag_r      <= '0;
      lead_r     <= '0;
      extra_r    <= '0;
      lit_r      <= '0;
      copy_r     <= '0;
      dist_r     <= '0;
      prod_r     <= '0;
      wptr_r     <= '0;
      fin_r      <= ST_RUN;
      stop_r     <= 1'b0;
      idone_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        expected_r <= cfg_wr_data;
      end
      if (in_fire) begin
        phase_r <= phase_nxt;
        tag_r   <= tag_nxt;
        lead_r  <= lead_nxt;
        extra_r <= extra_nxt;
        lit_r   <= lit_nxt;
        copy_r  <= copy_nxt;
        dist_r  <= dist_nxt;
        prod_r  <= prod_nxt;
        wptr_r  <= wptr_nxt;
        fin_r   <= fin_nxt;
        stop_r  <= stop_nxt;
        idone_r <= idone_nxt;
      end
    end
  end

endmodule

FILE: hw/rtl/rplzd_outq.sv
// ----------------------------------------------------------------------------
// rplzd_outq
// Small result queue between the byte stage and the output channel. Absorbs
// output stalls so the history read data is never held.
// ----------------------------------------------------------------------------
module rplzd_outq
  import rplzd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rplzd_out_t       push_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rplzd_out_t       out_data,
  output logic [OQ_CW-1:0] level
);

  rplzd_out_t       ent_r [OQ_DEPTH];
  logic [OQ_AW-1:0] head_r, head_nxt;
  logic [OQ_AW-1:0] tail_r, tail_nxt;
  logic [OQ_CW-1:0] count_r, count_nxt;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_data  = ent_r[head_r];
  assign level     = count_r;
  assign pop       = out_valid && !out_stall;

  // Advance pointers and occupancy
  always_comb begin
    head_nxt  = pop  ? head_r + OQ_AW'(1) : head_r;
    tail_nxt  = push ? tail_r + OQ_AW'(1) : tail_r;
    count_nxt = count_r + OQ_CW'(push) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[tail_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/refpack_lz_decompressor_unit.sv
// ----------------------------------------------------------------------------
// refpack_lz_decompressor_unit
// Pipeline: an input transfer is parsed and issues its history read, the byte
//   stage resolves the byte, then the result queue presents it on out_valid.
// Throughput: one item per cycle while in_stall is low, set by the single read and single write
//   port of the history RAM; a 4-entry result queue rides out output stalls.
// Reset (rst_n, synchronous): clears parser state, counters, status and queue;
//   history contents are undefined until written and are never cleared.
// ----------------------------------------------------------------------------
module refpack_lz_decompressor_unit
  import rplzd_pkg::*;
#(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DFLT,
  parameter int COUNT_BITS   = COUNT_BITS_DFLT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  rplzd_in_t         in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rplzd_out_t        out_data
);

  localparam int AW = $clog2(WINDOW_BYTES);

  logic             in_fire;
  rplzd_req_t       req;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       ram_rd_data;
  logic [OQ_CW-1:0] oq_level;
  logic [OQ_CW-1:0] occupancy;

  // Byte stage
  logic             s1_valid_r;
  rplzd_req_t       s1_req_r;
  logic [AW-1:0]    s1_waddr_r;
  logic             fwd_r;
  logic [7:0]       fwd_byte_r;
  logic [7:0]       s1_byte;
  logic             s1_write;
  logic             fwd_nxt;
  rplzd_out_t       push_data;

  // Accept while the queue has room for the item in flight and this one
  assign occupancy = oq_level + OQ_CW'(s1_valid_r);
  assign in_stall  = (occupancy >= OQ_HIWAT);
  assign in_fire   = in_valid && !in_stall;

  rplzd_ctrl #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .in_data     (in_data),
    .req         (req),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr)
  );

  rplzd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_hist (
    .clk     (clk),
    .wr_en   (s1_write),
    .wr_addr (s1_waddr_r),
    .wr_data (s1_byte),
    .rd_en   (in_fire && req.from_hist),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // Resolve the output byte: literal, forwarded write, or history read
  always_comb begin
    s1_byte = 8'h00;
    if (s1_req_r.emit) begin
      if (s1_req_r.from_hist) begin
        s1_byte = fwd_r ? fwd_byte_r : ram_rd_data;
      end else begin
        s1_byte = s1_req_r.lit_byte;
      end
    end
  end

  assign s1_write = s1_valid_r && s1_req_r.emit;

  // Forward when the read hits the entry being written this cycle
  assign fwd_nxt = in_fire && req.from_hist && s1_write && (rd_addr == s1_waddr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      fwd_r      <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r   <= req;
      s1_waddr_r <= wr_addr;
      fwd_byte_r <= s1_byte;
    end
  end

  assign push_data.out_valid    = s1_req_r.emit;
  assign push_data.out_byte     = s1_byte;
  assign push_data.copy_pending = s1_req_r.copy_pending;
  assign push_data.status       = s1_req_r.status;

  rplzd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .level     (oq_level)
  );

  // Queue never takes a transfer beyond its depth
  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (oq_level < OQ_CW'(OQ_DEPTH)))
    else $error("result queue overflow");

  // Forwarding only applies to a history copy in the byte stage
  a_fwd_copy: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> (s1_valid_r && s1_req_r.from_hist))
    else $error("forward flag without history read");

  // A final status holds for every later item
  a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_req_r.status != ST_RUN && in_fire) |-> (req.status == s1_req_r.status))
    else $error("final status changed");

endmodule
